FILE: rtl/cicp_pkg.sv
// Shared types, codes and helpers for the cascaded interrupt controller pair.
// No dependencies; used by cascaded_interrupt_controller_pair_core.
`timescale 1ns / 1ps
`default_nettype none

package cicp_pkg;

  // bus action codes
  localparam logic [2:0] ACT_WRITE = 3'd0;
  localparam logic [2:0] ACT_READ  = 3'd1;
  localparam logic [2:0] ACT_RAISE = 3'd2;
  localparam logic [2:0] ACT_LOWER = 3'd3;
  localparam logic [2:0] ACT_IACK  = 3'd4;

  localparam logic [7:0] MASTER_BASE = 8'h20;
  localparam logic [7:0] SLAVE_BASE  = 8'hA0;

  // command decode masks and patterns on the even port
  localparam logic [7:0] OCW3_MASK  = 8'h98;
  localparam logic [7:0] OCW3_CODE  = 8'h08;
  localparam logic [7:0] OCW_SEL    = 8'h18;
  localparam logic [7:0] OCW2_TYPE  = 8'hE0;
  localparam logic [7:0] OCW2_NOP   = 8'h40;
  localparam logic [7:0] VEC_MASK   = 8'hF8;
  localparam logic [7:0] POLL_FLAG  = 8'h80;

  localparam logic [2:0] STEP_DONE  = 3'd4;
  localparam logic [3:0] NO_LINE    = 4'd8;
  localparam logic [2:0] SPURIOUS   = 3'd7;
  localparam int unsigned CASCADE_IR = 2;

  localparam int unsigned IN_W  = 23;
  localparam int unsigned OUT_W = 18;

  typedef struct packed {
    logic [7:0] irr;
    logic [7:0] isr;
  } ack_result_t;

  // index of lowest set bit, NO_LINE when none
  function automatic logic [3:0] lowest_bit(input logic [7:0] v);
    logic [3:0] res;
    res = NO_LINE;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) res = 4'(i);
    end
    return res;
  endfunction

  function automatic logic [7:0] pending(input logic [2:0] step, input logic [7:0] irr,
                                         input logic [7:0] imr, input logic [7:0] isr);
    if (step < STEP_DONE) return 8'h00;
    return irr & ~imr & ~isr;
  endfunction

  // clear the lowest set service bit
  function automatic logic [7:0] clear_lowest(input logic [7:0] v);
    return v & (v - 8'd1);
  endfunction

  function automatic ack_result_t ack_update(input logic [7:0] irr, input logic [7:0] isr,
                                             input logic [2:0] ir, input logic aeoi);
    ack_result_t r;
    r.irr = irr & ~(8'd1 << ir);
    r.isr = isr | (8'd1 << ir);
    if (aeoi) r.isr = clear_lowest(r.isr);
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cascaded_interrupt_controller_pair_core.sv
// Top level: master/slave interrupt controller pair behind stream handshakes.
// Depends on cicp_pkg.
//
//   channel  dir  width  contents (lowest bit first)
//   s_*      in   24     action[2:0] port_address[10:3] write_data[18:11] irq_line[22:19]
//   m_*      out  24     read_data[7:0] claimed[8] vector[16:9] int_pending[17]
//
// One transfer per cycle sustained while results are accepted. Each transfer waits in
// the input register, then the controller logic updates state and loads
// the result register. Reset (rst, synchronous) restores power-on controller state.
// A stalled result holds the input register; one more input is taken while the result
// waits, after which s_tready stays low until the result is accepted.
`timescale 1ns / 1ps
`default_nettype none

module cascaded_interrupt_controller_pair_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // action, port_address, write_data, irq_line
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0] m_tdata         // read_data, claimed, vector, int_pending
);

  // controller state, index 0 master, 1 slave
  logic [7:0] irr  [2];
  logic [7:0] isr  [2];
  logic [7:0] imr  [2];
  logic [7:0] lvl  [2];
  logic [7:0] icw  [2][4];
  logic [2:0] step [2];
  logic       rsel [2];
  logic       poll [2];

  logic [7:0] irr_next  [2];
  logic [7:0] isr_next  [2];
  logic [7:0] imr_next  [2];
  logic [7:0] lvl_next  [2];
  logic [7:0] icw_next  [2][4];
  logic [2:0] step_next [2];
  logic       rsel_next [2];
  logic       poll_next [2];

  logic                          in_valid;
  logic [cicp_pkg::IN_W-1:0]     in_q;
  logic [cicp_pkg::OUT_W-1:0]    out_q;
  logic [cicp_pkg::OUT_W-1:0]    out_next;
  logic                          advance;

  logic [2:0] action;
  logic [7:0] port_address;
  logic [7:0] write_data;
  logic [3:0] irq_line;

  assign action       = in_q[2:0];
  assign port_address = in_q[10:3];
  assign write_data   = in_q[18:11];
  assign irq_line     = in_q[22:19];

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tdata  = {6'd0, out_q};

  always_comb begin
    logic [7:0] rd;
    logic       claimed;
    logic [7:0] vec;
    logic       p;
    logic       hit;
    logic [3:0] ir;
    logic [3:0] s;
    logic [2:0] st;
    logic [7:0] bitm;
    cicp_pkg::ack_result_t ar;

    rd = 8'd0;
    claimed = 1'b0;
    vec = 8'd0;
    p = 1'b0;
    hit = 1'b0;
    ir = cicp_pkg::NO_LINE;
    s = cicp_pkg::NO_LINE;
    st = 3'd0;
    bitm = 8'd0;
    ar = '0;
    for (int i = 0; i < 2; i++) begin
      irr_next[i]  = irr[i];
      isr_next[i]  = isr[i];
      imr_next[i]  = imr[i];
      lvl_next[i]  = lvl[i];
      step_next[i] = step[i];
      rsel_next[i] = rsel[i];
      poll_next[i] = poll[i];
      for (int k = 0; k < 4; k++) icw_next[i][k] = icw[i][k];
    end

    case (action)
      cicp_pkg::ACT_WRITE, cicp_pkg::ACT_READ: begin
        if (port_address[7:1] == cicp_pkg::SLAVE_BASE[7:1]) begin
          hit = 1'b1;
          p = 1'b1;
        end else if (port_address[7:1] == cicp_pkg::MASTER_BASE[7:1]) begin
          hit = 1'b1;
        end
        if (hit) begin
          claimed = 1'b1;
          if (action == cicp_pkg::ACT_WRITE) begin
            if (!port_address[0]) begin
              if (write_data[4]) begin
                // ICW1 restarts the init sequence
                irr_next[p]    = 8'd0;
                imr_next[p]    = 8'd0;
                icw_next[p][0] = write_data;
                icw_next[p][2] = 8'd7;
                if (!write_data[0]) icw_next[p][3] = 8'd0;
                rsel_next[p]   = 1'b0;
                step_next[p]   = 3'd1;
              end else if ((write_data & cicp_pkg::OCW3_MASK) == cicp_pkg::OCW3_CODE) begin
                poll_next[p] = write_data[2];
                if (write_data[1]) rsel_next[p] = write_data[0];
              end else if ((write_data & cicp_pkg::OCW_SEL) == 8'd0) begin
                if ((write_data & cicp_pkg::OCW2_TYPE) != cicp_pkg::OCW2_NOP && write_data[5])
                  isr_next[p] = cicp_pkg::clear_lowest(isr[p]);
              end
            end else if (step[p] < cicp_pkg::STEP_DONE) begin
              icw_next[p][step[p][1:0]] = write_data;
              st = step[p] + 3'd1;
              // skip ICW3 in single mode, ICW4 when not requested
              if (st == 3'd2 && icw_next[p][0][1]) st = st + 3'd1;
              if (st == 3'd3 && !icw_next[p][0][0]) st = st + 3'd1;
              step_next[p] = st;
            end else begin
              imr_next[p] = write_data;
            end
          end else begin
            if (poll[p]) begin
              poll_next[p] = 1'b0;
              ir = cicp_pkg::lowest_bit(cicp_pkg::pending(step[p], irr[p], imr[p], isr[p]));
              if (!ir[3]) begin
                ar = cicp_pkg::ack_update(irr[p], isr[p], ir[2:0], icw[p][3][1]);
                irr_next[p] = ar.irr;
                isr_next[p] = ar.isr;
                if (p) begin
                  lvl_next[0][cicp_pkg::CASCADE_IR] = 1'b0;
                  irr_next[0][cicp_pkg::CASCADE_IR] = 1'b0;
                end
                rd = cicp_pkg::POLL_FLAG | {5'd0, ir[2:0]};
              end
            end else if (port_address[0]) begin
              rd = imr[p];
            end else begin
              rd = rsel[p] ? isr[p] : irr[p];
            end
          end
        end
      end
      cicp_pkg::ACT_RAISE: begin
        p = irq_line[3];
        bitm = 8'd1 << irq_line[2:0];
        if ((lvl[p] & bitm) == 8'd0) begin
          lvl_next[p] = lvl[p] | bitm;
          irr_next[p] = irr[p] | bitm;
        end
      end
      cicp_pkg::ACT_LOWER: begin
        p = irq_line[3];
        bitm = 8'd1 << irq_line[2:0];
        if ((lvl[p] & bitm) != 8'd0) begin
          lvl_next[p] = lvl[p] & ~bitm;
          irr_next[p] = irr[p] & ~bitm;
        end
      end
      cicp_pkg::ACT_IACK: begin
        ir = cicp_pkg::lowest_bit(cicp_pkg::pending(step[0], irr[0], imr[0], isr[0]));
        if (ir[3]) begin
          vec = (icw[0][1] & cicp_pkg::VEC_MASK) | {5'd0, cicp_pkg::SPURIOUS};
        end else begin
          ar = cicp_pkg::ack_update(irr[0], isr[0], ir[2:0], icw[0][3][1]);
          irr_next[0] = ar.irr;
          isr_next[0] = ar.isr;
          if (!icw[0][0][1] && icw[0][2][ir[2:0]]) begin
            if (icw[1][2][2:0] == ir[2:0]) begin
              // cascaded line: the slave supplies the vector
              s = cicp_pkg::lowest_bit(cicp_pkg::pending(step[1], irr[1], imr[1], isr[1]));
              if (s[3]) begin
                s = {1'b0, cicp_pkg::SPURIOUS};
              end else begin
                ar = cicp_pkg::ack_update(irr[1], isr[1], s[2:0], icw[1][3][1]);
                irr_next[1] = ar.irr;
                isr_next[1] = ar.isr;
                lvl_next[0][cicp_pkg::CASCADE_IR] = 1'b0;
                irr_next[0][cicp_pkg::CASCADE_IR] = 1'b0;
              end
              vec = (icw[1][1] & cicp_pkg::VEC_MASK) | {5'd0, s[2:0]};
            end else begin
              vec = (icw[0][1] & cicp_pkg::VEC_MASK) | {5'd0, cicp_pkg::SPURIOUS};
            end
          end else begin
            vec = (icw[0][1] & cicp_pkg::VEC_MASK) | {5'd0, ir[2:0]};
          end
        end
      end
      default: begin
      end
    endcase

    // slave request drives master IR2
    if (cicp_pkg::pending(step_next[1], irr_next[1], imr_next[1], isr_next[1]) != 8'd0 &&
        !lvl_next[0][cicp_pkg::CASCADE_IR]) begin
      lvl_next[0][cicp_pkg::CASCADE_IR] = 1'b1;
      irr_next[0][cicp_pkg::CASCADE_IR] = 1'b1;
    end

    out_next = {cicp_pkg::pending(step_next[0], irr_next[0], imr_next[0], isr_next[0]) != 8'd0,
                vec, claimed, rd};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        irr[i]  <= 8'h00;
        isr[i]  <= 8'h00;
        imr[i]  <= 8'hFF;
        lvl[i]  <= 8'h00;
        step[i] <= 3'd0;
        rsel[i] <= 1'b0;
        poll[i] <= 1'b0;
        for (int k = 0; k < 4; k++) icw[i][k] <= 8'h00;
      end
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
        in_q     <= s_tdata[cicp_pkg::IN_W-1:0];
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
        out_q    <= out_next;
        for (int i = 0; i < 2; i++) begin
          irr[i]  <= irr_next[i];
          isr[i]  <= isr_next[i];
          imr[i]  <= imr_next[i];
          lvl[i]  <= lvl_next[i];
          step[i] <= step_next[i];
          rsel[i] <= rsel_next[i];
          poll[i] <= poll_next[i];
          for (int k = 0; k < 4; k++) icw[i][k] <= icw_next[i][k];
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  logic slave_req;
  logic master_req;
  assign slave_req  = cicp_pkg::pending(step[1], irr[1], imr[1], isr[1]) != 8'd0;
  assign master_req = cicp_pkg::pending(step[0], irr[0], imr[0], isr[0]) != 8'd0;

  a_cascade_line: assert property (@(posedge clk) disable iff (rst)
    slave_req |-> lvl[0][cicp_pkg::CASCADE_IR])
    else $error("slave request without master cascade line");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step[0] <= cicp_pkg::STEP_DONE && step[1] <= cicp_pkg::STEP_DONE)
    else $error("init step out of range");

  a_pending_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_q[cicp_pkg::OUT_W-1] == master_req)
    else $error("int_pending does not match master state");

  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid && !m_tready)
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

FILE: tb/cascaded_interrupt_controller_pair_core_test.sv
// Self-checking test of cascaded_interrupt_controller_pair_core: ICW/OCW traffic,
// port reads, line edges and acknowledge cycles, checked by a cycle-free predictor.
// Depends on cicp_pkg and the core RTL.
`timescale 1ns / 1ps

module cascaded_interrupt_controller_pair_core_test;

  class pic_pair_scoreboard;
    typedef struct {
      logic [7:0] read_data;
      logic       claimed;
      logic [7:0] vector;
      logic       int_pending;
    } response_t;

    response_t expected_responses[$];
    int failures, checked;
    int n_writes, n_reads, n_edges, n_acks, n_slave_vectors;

    // index 0 master, 1 slave
    logic [7:0] irr[2], isr[2], imr[2], lvl[2];
    logic [7:0] icw[8];
    logic [2:0] init_stage[2], last_line[2];
    logic       isr_select[2], poll_armed[2];

    function new();
      for (int p = 0; p < 2; p++) begin
        irr[p] = '0;
        isr[p] = '0;
        imr[p] = 8'hFF;
        lvl[p] = '0;
        init_stage[p] = '0;
        last_line[p] = '0;
        isr_select[p] = 1'b0;
        poll_armed[p] = 1'b0;
      end
      foreach (icw[i]) icw[i] = '0;
    endfunction

    function int outstanding();
      return expected_responses.size();
    endfunction

    function int first_set(logic [7:0] v);
      for (int i = 0; i < 8; i++) if (v[i]) return i;
      return 8;
    endfunction

    // a controller still in its ICW sequence offers nothing
    function logic [7:0] live_requests(int p);
      if (init_stage[p] < cicp_pkg::STEP_DONE) return '0;
      return irr[p] & ~imr[p] & ~isr[p];
    endfunction

    function void clear_top_service(int p);
      int b;
      b = first_set(isr[p]);
      if (b < 8) isr[p][b] = 1'b0;
    endfunction

    function void take_line(int p, int ir);
      irr[p][ir] = 1'b0;
      isr[p][ir] = 1'b1;
      if (icw[p*4 + 3][1]) clear_top_service(p);
      if (p == 1) begin
        lvl[0][cicp_pkg::CASCADE_IR] = 1'b0;
        irr[0][cicp_pkg::CASCADE_IR] = 1'b0;
      end
    endfunction

    function logic [7:0] poll_byte(int p);
      int ir;
      ir = first_set(live_requests(p));
      if (ir >= 8) return '0;
      take_line(p, ir);
      last_line[p] = 3'(ir);
      return cicp_pkg::POLL_FLAG | 8'(ir);
    endfunction

    function void write_port(int p, bit odd, logic [7:0] v);
      if (!odd) begin
        if (v[4]) begin
          irr[p] = '0;
          imr[p] = '0;
          icw[p*4] = v;
          icw[p*4 + 2] = 8'd7;
          if (!v[0]) icw[p*4 + 3] = '0;
          isr_select[p] = 1'b0;
          init_stage[p] = 3'd1;
        end else if ((v & cicp_pkg::OCW3_MASK) == cicp_pkg::OCW3_CODE) begin
          poll_armed[p] = v[2];
          if (v[1]) isr_select[p] = v[0];
        end else if ((v & cicp_pkg::OCW_SEL) == 8'h00) begin
          // any EOI form except the no-op rotate code
          if ((v & cicp_pkg::OCW2_TYPE) != cicp_pkg::OCW2_NOP && v[5]) clear_top_service(p);
        end
        return;
      end
      if (init_stage[p] < cicp_pkg::STEP_DONE) begin
        icw[p*4 + init_stage[p][1:0]] = v;
        init_stage[p]++;
        if (init_stage[p] == 3'd2 && icw[p*4][1]) init_stage[p]++;
        if (init_stage[p] == 3'd3 && !icw[p*4][0]) init_stage[p]++;
      end else begin
        imr[p] = v;
      end
    endfunction

    function logic [7:0] read_port(int p, bit odd);
      if (poll_armed[p]) begin
        poll_armed[p] = 1'b0;
        return poll_byte(p);
      end
      if (odd) return imr[p];
      return isr_select[p] ? isr[p] : irr[p];
    endfunction

    function logic [7:0] ack_vector();
      int ir, s;
      ir = first_set(live_requests(0));
      if (ir >= 8) begin
        last_line[0] = cicp_pkg::SPURIOUS;
        return {icw[1][7:3], cicp_pkg::SPURIOUS};
      end
      take_line(0, ir);
      if (!icw[0][1] && icw[2][ir]) begin
        if (int'(icw[6][2:0]) == ir) begin
          s = first_set(live_requests(1));
          if (s >= 8) s = cicp_pkg::SPURIOUS;
          else begin
            take_line(1, s);
            n_slave_vectors++;
          end
          last_line[1] = 3'(s);
          return {icw[5][7:3], 3'(s)};
        end
        last_line[0] = cicp_pkg::SPURIOUS;
        return {icw[1][7:3], cicp_pkg::SPURIOUS};
      end
      last_line[0] = 3'(ir);
      return {icw[1][7:3], 3'(ir)};
    endfunction

    function void note_input(logic [23:0] d);
      logic [2:0] act;
      logic [7:0] port, data;
      logic [3:0] line;
      int p;
      response_t r;
      act  = d[2:0];
      port = d[10:3];
      data = d[18:11];
      line = d[22:19];
      r = '{8'h00, 1'b0, 8'h00, 1'b0};
      case (act)
        cicp_pkg::ACT_WRITE, cicp_pkg::ACT_READ: begin
          if ({port[7:1], 1'b0} == cicp_pkg::SLAVE_BASE) p = 1;
          else if ({port[7:1], 1'b0} == cicp_pkg::MASTER_BASE) p = 0;
          else p = 2;
          if (p < 2) begin
            r.claimed = 1'b1;
            if (act == cicp_pkg::ACT_WRITE) begin
              write_port(p, port[0], data);
              n_writes++;
            end else begin
              r.read_data = read_port(p, port[0]);
              n_reads++;
            end
          end
        end
        cicp_pkg::ACT_RAISE: begin
          p = line[3];
          if (!lvl[p][line[2:0]]) begin
            lvl[p][line[2:0]] = 1'b1;
            irr[p][line[2:0]] = 1'b1;
          end
          n_edges++;
        end
        cicp_pkg::ACT_LOWER: begin
          p = line[3];
          if (lvl[p][line[2:0]]) begin
            lvl[p][line[2:0]] = 1'b0;
            irr[p][line[2:0]] = 1'b0;
          end
          n_edges++;
        end
        cicp_pkg::ACT_IACK: begin
          r.vector = ack_vector();
          n_acks++;
        end
        default: ;
      endcase
      // slave request drives the master cascade input
      if (live_requests(1) != 0 && !lvl[0][cicp_pkg::CASCADE_IR]) begin
        lvl[0][cicp_pkg::CASCADE_IR] = 1'b1;
        irr[0][cicp_pkg::CASCADE_IR] = 1'b1;
      end
      r.int_pending = (live_requests(0) != 0);
      expected_responses.push_back(r);
    endfunction

    function void check_result(logic [23:0] d);
      response_t e;
      if (expected_responses.size() == 0) begin
        $error("result %h arrived with nothing expected", d);
        failures++;
        return;
      end
      e = expected_responses.pop_front();
      checked++;
      if (d[7:0] !== e.read_data) begin
        $error("read_data: expected %h, got %h", e.read_data, d[7:0]);
        failures++;
      end
      if (d[8] !== e.claimed) begin
        $error("claimed: expected %b, got %b", e.claimed, d[8]);
        failures++;
      end
      if (d[16:9] !== e.vector) begin
        $error("vector: expected %h, got %h", e.vector, d[16:9]);
        failures++;
      end
      if (d[17] !== e.int_pending) begin
        $error("int_pending: expected %b, got %b", e.int_pending, d[17]);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  pic_pair_scoreboard board = new();
  int burst_left = 0;
  int issued = 0;

  cascaded_interrupt_controller_pair_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_input(s_tdata);
      if (m_tvalid && m_tready) board.check_result(m_tdata);
    end
  end

  // receiver: runs of free flow, light and heavy back-pressure
  initial begin
    int mode, len;
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(4, 60);
      repeat (len) begin
        @(posedge clk);
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 7) != 0);
          default: m_tready <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  function automatic logic [23:0] pack_item(logic [2:0] act, logic [7:0] port,
                                            logic [7:0] data, logic [3:0] line);
    return {1'b0, line, data, port, act};
  endfunction

  task automatic send_item(input logic [23:0] d);
    s_tdata <= d;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic pause_sender(input int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic issue(input logic [23:0] d);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
    end
    burst_left--;
    send_item(d);
    issued++;
  endtask

  task automatic write_reg(input logic [7:0] port, input logic [7:0] data);
    issue(pack_item(cicp_pkg::ACT_WRITE, port, data, 4'd0));
  endtask

  // full ICW sequence with random content, mostly a sane cascade setup
  task automatic init_controller(input int p);
    logic [7:0] base, icw1, icw3, icw4;
    base = p ? cicp_pkg::SLAVE_BASE : cicp_pkg::MASTER_BASE;
    icw1 = {3'($urandom), 1'b1, 2'($urandom), $urandom_range(0, 5) == 0,
            $urandom_range(0, 5) != 0};
    write_reg(base, icw1);
    write_reg(base | 8'd1, 8'($urandom));
    if (!icw1[1]) begin
      icw3 = p ? 8'h02 : 8'h04;
      if ($urandom_range(0, 4) == 0) icw3 = 8'($urandom);
      write_reg(base | 8'd1, icw3);
    end
    if (icw1[0]) begin
      icw4 = {6'd0, $urandom_range(0, 3) == 0, 1'b1};
      if ($urandom_range(0, 5) == 0) icw4 = 8'($urandom);
      write_reg(base | 8'd1, icw4);
    end
  endtask

  task automatic random_item();
    int kind;
    logic [7:0] base;
    kind = $urandom_range(0, 99);
    base = $urandom_range(0, 1) ? cicp_pkg::SLAVE_BASE : cicp_pkg::MASTER_BASE;
    if (kind < 30) begin
      issue(pack_item($urandom_range(0, 4) < 3 ? cicp_pkg::ACT_RAISE : cicp_pkg::ACT_LOWER,
                      8'($urandom), 8'($urandom), 4'($urandom)));
    end else if (kind < 45) begin
      issue(pack_item(cicp_pkg::ACT_IACK, 8'($urandom), 8'($urandom), 4'($urandom)));
    end else if (kind < 55) begin
      write_reg(base | 8'd1, 8'($urandom & $urandom & $urandom));
    end else if (kind < 65) begin
      if ($urandom_range(0, 1))
        write_reg(base, {3'($urandom) | {2'b00, $urandom_range(0, 2) != 0}, 2'b00,
                         3'($urandom)} | 8'h00);
      else
        write_reg(base, {1'b0, 2'($urandom), 2'b01, 3'($urandom)});
    end else if (kind < 80) begin
      issue(pack_item(cicp_pkg::ACT_READ, base | 8'($urandom_range(0, 1)), 8'($urandom),
                      4'($urandom)));
    end else if (kind < 83) begin
      init_controller($urandom_range(0, 1));
    end else begin
      issue(24'($urandom_range(0, 23'h7FFFFF)));
    end
  endtask

  initial begin
    int guard;
    bit held;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: disabled controllers, bring-up, cascade, ISR read, EOI, poll
    issue(pack_item(cicp_pkg::ACT_READ, cicp_pkg::MASTER_BASE | 8'd1, 8'h00, 4'd0));
    issue(pack_item(cicp_pkg::ACT_RAISE, 8'h00, 8'h00, 4'd3));
    issue(pack_item(cicp_pkg::ACT_IACK, 8'h00, 8'h00, 4'd0));
    write_reg(cicp_pkg::MASTER_BASE, 8'h11);
    write_reg(cicp_pkg::MASTER_BASE | 8'd1, 8'h08);
    write_reg(cicp_pkg::MASTER_BASE | 8'd1, 8'h04);
    write_reg(cicp_pkg::MASTER_BASE | 8'd1, 8'h01);
    write_reg(cicp_pkg::SLAVE_BASE, 8'h11);
    write_reg(cicp_pkg::SLAVE_BASE | 8'd1, 8'h70);
    write_reg(cicp_pkg::SLAVE_BASE | 8'd1, 8'h02);
    write_reg(cicp_pkg::SLAVE_BASE | 8'd1, 8'h01);
    issue(pack_item(cicp_pkg::ACT_RAISE, 8'h00, 8'h00, 4'd15));
    issue(pack_item(cicp_pkg::ACT_RAISE, 8'h00, 8'h00, 4'd0));
    issue(pack_item(cicp_pkg::ACT_RAISE, 8'h00, 8'h00, 4'd0));
    issue(pack_item(cicp_pkg::ACT_IACK, 8'h00, 8'h00, 4'd0));
    issue(pack_item(cicp_pkg::ACT_IACK, 8'h00, 8'h00, 4'd0));
    write_reg(cicp_pkg::MASTER_BASE, 8'h0B);
    issue(pack_item(cicp_pkg::ACT_READ, cicp_pkg::MASTER_BASE, 8'h00, 4'd0));
    write_reg(cicp_pkg::MASTER_BASE, 8'h60);
    write_reg(cicp_pkg::MASTER_BASE, 8'h40);
    issue(pack_item(cicp_pkg::ACT_RAISE, 8'h00, 8'h00, 4'd9));
    write_reg(cicp_pkg::SLAVE_BASE, 8'h0C);
    issue(pack_item(cicp_pkg::ACT_READ, cicp_pkg::SLAVE_BASE | 8'd1, 8'h00, 4'd0));
    issue(pack_item(cicp_pkg::ACT_LOWER, 8'h00, 8'h00, 4'd3));
    write_reg(8'hFF, 8'hFF);
    issue(24'h7FFFFF);

    held = 1'b0;
    while (issued < 2000) begin
      random_item();
      if (!held && issued >= 1000) begin
        // hold off until the pipeline drains completely
        held = 1'b1;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.outstanding() != 0) @(posedge clk);
        burst_left = 0;
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (board.outstanding() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (board.outstanding() != 0) begin
      $error("%0d expected results never arrived", board.outstanding());
      board.failures++;
    end

    $display("covered %0d port writes, %0d port reads, %0d line edges, %0d acknowledges",
             board.n_writes, board.n_reads, board.n_edges, board.n_acks);
    $display("%0d slave-supplied vectors; %0d results checked, %0d mismatches",
             board.n_slave_vectors, board.checked, board.failures);
    if (board.failures == 0) begin
      $display("** cascaded_interrupt_controller_pair_core: PASSED **");
    end else begin
      $display("** cascaded_interrupt_controller_pair_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("run did not complete in time");
    $display("** cascaded_interrupt_controller_pair_core: FAILED **");
    $finish;
  end

endmodule
